// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, off during reset.
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge, off during reset.
`define ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dit_pkg.sv =====
`default_nettype none

package dit_pkg;

  localparam int NUM_SOURCES       = 6;
  localparam int TIMER_SRC         = 3;
  localparam int DEF_STACK_LEVELS  = 8;

  localparam logic [5:0]  ENABLE_RESET = 6'd9;
  localparam logic [15:0] PERIOD_RESET = 16'hFFFF;
  localparam logic [15:0] TIMER_RESET  = 16'hFFFF;

  // Interrupt vectors, in priority order
  localparam logic [15:0] VEC_INT0     = 16'h0002;
  localparam logic [15:0] VEC_INT1     = 16'h0004;
  localparam logic [15:0] VEC_INT2     = 16'h0006;
  localparam logic [15:0] VEC_TIMER    = 16'h0018;
  localparam logic [15:0] VEC_RECEIVE  = 16'h001A;
  localparam logic [15:0] VEC_TRANSMIT = 16'h001C;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_ENABLE_MASK  = 1'b0,
    CFG_TIMER_PERIOD = 1'b1
  } cfg_reg_t;

  // One boundary step as it arrives
  typedef struct packed {
    logic [5:0]  raise_flags;
    logic [15:0] next_pc;
    logic        enter_idle;
    logic        set_global_mask;
    logic        clear_global_mask;
  } item_t;

  // One boundary result
  typedef struct packed {
    logic [15:0] exec_pc;
    logic        executes;
    logic        took_interrupt;
    logic [5:0]  flags_now;
    logic [15:0] timer_now;
    logic        timer_irq_pending;
    logic        global_mask_now;
    logic [15:0] stack_top;
    logic [3:0]  stack_used;
  } res_t;

  // Vector for a one-hot grant over the six sources
  function automatic logic [15:0] vector_of(input logic [NUM_SOURCES-1:0] grant);
    logic [15:0] vec;
    vec = '0;
    case (grant)
      6'b000001: vec = VEC_INT0;
      6'b000010: vec = VEC_INT1;
      6'b000100: vec = VEC_INT2;
      6'b001000: vec = VEC_TIMER;
      6'b010000: vec = VEC_RECEIVE;
      6'b100000: vec = VEC_TRANSMIT;
      default:   vec = '0;
    endcase
    return vec;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dit_in_reg.sv =====
`default_nettype none

module dit_in_reg
  import dit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t in_item,
  input  wire logic  in_valid,
  output logic       in_ready,
  output item_t      item,
  output logic       item_valid,
  input  wire logic  item_ready
);

  // Take a new transfer when empty or when the held item moves on
  assign in_ready = !item_valid || item_ready;

  // Hold valid across stalls, drop it once consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  // Capture payload on each accepted transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dit_core.sv =====
`default_nettype none

module dit_core
  import dit_pkg::*;
#(
  parameter int STACK_LEVELS = DEF_STACK_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire item_t       item,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [5:0]  enable_mask,
  input  wire logic [15:0] timer_period,
  output res_t             res,
  output logic             res_valid,
  input  wire logic        res_ready
);

  localparam int LEVEL_W = $clog2(STACK_LEVELS + 1);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(STACK_LEVELS);

  // Architectural state
  logic [5:0]         flags;
  logic               gmask;
  logic               halted;
  logic [15:0]        tcount;
  logic               tevent;
  logic [LEVEL_W-1:0] level;
  logic [15:0]        stack [STACK_LEVELS];

  logic [5:0]         flags_raised;
  logic [5:0]         flags_fold;
  logic               gmask_req;
  logic               halt_req;
  logic [5:0]         pending;
  logic [5:0]         grant;
  logic               take;
  logic [5:0]         flags_next;
  logic               gmask_next;
  logic               halted_next;
  logic [15:0]        tcount_next;
  logic               tevent_next;
  logic [LEVEL_W-1:0] level_next;
  logic [15:0]        top_next;
  logic               fire;
  res_t               res_next;

  // Step when an item is held and the result register can take it
  assign item_ready = !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  // Apply raise, mask and idle requests, then fold the timer and arbitrate
  always_comb begin
    flags_raised = flags | item.raise_flags;
    gmask_req    = item.set_global_mask || (gmask && !item.clear_global_mask);
    halt_req     = halted || item.enter_idle;
    flags_fold   = flags_raised;
    flags_fold[TIMER_SRC] = flags_raised[TIMER_SRC] | tevent;
    pending      = gmask_req ? '0 : (flags_fold & enable_mask);
    grant        = pending & (~pending + 6'd1);
    take         = |pending;
    flags_next   = gmask_req ? flags_raised : (flags_fold & ~grant);
    gmask_next   = gmask_req || take;
    halted_next  = halt_req && !take;
  end

  // Tick the timer; a reload pends a timer event when the source is enabled
  always_comb begin
    tcount_next = (tcount == '0) ? timer_period : tcount - 16'd1;
    tevent_next = (tevent && !grant[TIMER_SRC]) ||
                  ((tcount_next == timer_period) && enable_mask[TIMER_SRC]);
  end

  // Push bookkeeping: saturate the level, the newest entry sits at slot zero
  always_comb begin
    if (take && (level != LEVEL_FULL)) begin
      level_next = level + LEVEL_W'(1);
    end else begin
      level_next = level;
    end
    if (take) begin
      top_next = item.next_pc;
    end else if (level == '0) begin
      top_next = '0;
    end else begin
      top_next = stack[0];
    end
  end

  // Assemble the result
  always_comb begin
    res_next.exec_pc           = take ? vector_of(grant) : item.next_pc;
    res_next.executes          = !halted_next;
    res_next.took_interrupt    = take;
    res_next.flags_now         = flags_next;
    res_next.timer_now         = tcount_next;
    res_next.timer_irq_pending = tevent_next;
    res_next.global_mask_now   = gmask_next;
    res_next.stack_top         = top_next;
    res_next.stack_used        = 4'(level_next);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      flags  <= '0;
      gmask  <= 1'b0;
      halted <= 1'b0;
      tcount <= TIMER_RESET;
      tevent <= 1'b0;
      level  <= '0;
    end else if (fire) begin
      flags  <= flags_next;
      gmask  <= gmask_next;
      halted <= halted_next;
      tcount <= tcount_next;
      tevent <= tevent_next;
      level  <= level_next;
    end
  end

  // Return stack: shift on push, the oldest entry falls off the end
  always_ff @(posedge clk) begin
    if (fire && take) begin
      stack[0] <= item.next_pc;
      for (int i = 1; i < STACK_LEVELS; i++) begin
        stack[i] <= stack[i-1];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsp_interrupt_timer_boundary_unit.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   32     one instruction boundary step
// m_axis    out  64     boundary result, one per step
// cfg       in   16     enable mask (index 0), timer period (index 1)
//
// One step per clock unless m_axis_tready stalls: input register, one pass of logic,
// result register. A step passes the input register and then the result register
// before its result is offered on m_axis.
// Flag, mask, timer and stack state update in the cycle a step enters the
// result register; m_axis_tready low stalls the result register and, through
// it, the input register.
// Synchronous reset clears valids, flags, mask, halt, stack level and the
// timer event; the timer count restarts at 0xFFFF.
`default_nettype none

`include "assert_macros.svh"

module dsp_interrupt_timer_boundary_unit
  import dit_pkg::*;
#(
  parameter int STACK_LEVELS = DEF_STACK_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // raise_flags[5:0], next_pc[21:6], enter_idle[22], set_global_mask[23],
  // clear_global_mask[24], zero[31:25]
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // exec_pc[15:0], executes[16], took_interrupt[17], flags_now[23:18],
  // timer_now[39:24], timer_irq_pending[40], global_mask_now[41],
  // stack_top[57:42], stack_used[61:58], zero[63:62]
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [5:0]  enable_mask;
  logic [15:0] timer_period;
  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        item_ready;
  res_t        res;
  logic        res_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask  <= ENABLE_RESET;
      timer_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENABLE_MASK:  enable_mask  <= cfg_data[5:0];
        CFG_TIMER_PERIOD: timer_period <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Unpack the input transfer
  assign in_item.raise_flags       = s_axis_tdata[5:0];
  assign in_item.next_pc           = s_axis_tdata[21:6];
  assign in_item.enter_idle        = s_axis_tdata[22];
  assign in_item.set_global_mask   = s_axis_tdata[23];
  assign in_item.clear_global_mask = s_axis_tdata[24];

  dit_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  dit_core #(
    .STACK_LEVELS (STACK_LEVELS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .enable_mask  (enable_mask),
    .timer_period (timer_period),
    .res          (res),
    .res_valid    (res_valid),
    .res_ready    (m_axis_tready)
  );

  // Pack the result transfer
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {2'b00, res.stack_used, res.stack_top, res.global_mask_now,
                          res.timer_irq_pending, res.timer_now, res.flags_now,
                          res.took_interrupt, res.executes, res.exec_pc};

  `ASSERT_IMPLIES(a_take_sets_mask, clk, rst, res_valid && res.took_interrupt, res.global_mask_now && res.executes, "interrupt taken without mask set or with halt held")
  `ASSERT_IMPLIES(a_in_no_overrun, clk, rst, s_axis_tvalid && s_axis_tready, !item_valid || item_ready, "input transfer overwrote a held step")
  `ASSERT_NEXT(a_step_gives_result, clk, rst, item_valid && item_ready, res_valid, "step taken but no result followed")

endmodule

`default_nettype wire
